// ===== design/alin_pkg.sv =====
`timescale 1ns / 1ps

package alin_pkg;

  localparam int DEF_CODE_BITS = 12;
  localparam int DEF_FRAC_BITS = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd4;

  // sensor kinds
  localparam logic [2:0] OP_HUM   = 3'd0;
  localparam logic [2:0] OP_THERM = 3'd1;
  localparam logic [2:0] OP_DIE   = 3'd2;
  localparam logic [2:0] OP_REF   = 3'd3;
  localparam logic [2:0] OP_BAT   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // thermistor early-out flags
  localparam logic [1:0] TF_NONE = 2'd0;
  localparam logic [1:0] TF_MIN  = 2'd1;
  localparam logic [1:0] TF_MAX  = 2'd2;

  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = -24'sh800000;

  // datapath widths, sized for the widest code and fraction settings
  localparam int FS_W = 16;
  localparam int AW   = 33;
  localparam int BW   = 36;
  localparam int LW   = 57;
  localparam int PW   = 6;
  localparam int MW   = 32;
  localparam int FW   = 28;
  localparam int LNW  = 48;
  localparam int NW   = 62;
  localparam int DW   = 39;
  localparam int QB   = 25;
  localparam int DSW  = DW + QB;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] raw_code;
  } alin_in_t;

  typedef struct packed {
    logic signed [23:0] value;
    logic [1:0]         status;
  } alin_out_t;

  typedef struct packed {
    logic [2:0]     op;
    logic [1:0]     tflag;
    logic           neg;
    logic [LNW-1:0] lin_n;
  } side_t;

  typedef struct packed {
    logic [MW-1:0] mn;
    logic [MW-1:0] md;
    logic [FW-1:0] fn;
    logic [FW-1:0] fd;
    logic [PW-1:0] pn;
    logic [PW-1:0] pd;
    side_t         side;
  } log_tok_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] tflag;
    logic       neg;
    logic       ovf;
  } div_side_t;

  typedef struct packed {
    logic [NW-1:0]  rem;
    logic [DSW-1:0] dsh;
    logic [QB-1:0]  q;
    div_side_t      side;
  } div_tok_t;

endpackage

// ===== design/alin_log_cell.sv =====
`timescale 1ns / 1ps

module alin_log_cell import alin_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     v_in,
  input  log_tok_t tok_in,
  output logic     v_out,
  output log_tok_t tok_out
);

  logic [2*MW-1:0] sq_n, sq_d;
  logic [MW:0]     t_n, t_d;
  log_tok_t        tok_nxt;
  logic            v_r;
  log_tok_t        tok_r;

  // one fraction bit per cell for both lanes
  always_comb begin
    sq_n = 64'(tok_in.mn) * 64'(tok_in.mn);
    sq_d = 64'(tok_in.md) * 64'(tok_in.md);
    t_n  = sq_n[2*MW-1:MW-1];
    t_d  = sq_d[2*MW-1:MW-1];
    tok_nxt    = tok_in;
    tok_nxt.mn = t_n[MW] ? t_n[MW:1] : t_n[MW-1:0];
    tok_nxt.md = t_d[MW] ? t_d[MW:1] : t_d[MW-1:0];
    tok_nxt.fn = {tok_in.fn[FW-2:0], t_n[MW]};
    tok_nxt.fd = {tok_in.fd[FW-2:0], t_d[MW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    tok_r <= tok_nxt;
  end

  assign v_out   = v_r;
  assign tok_out = tok_r;

endmodule

// ===== design/alin_div_cell.sv =====
`timescale 1ns / 1ps

module alin_div_cell import alin_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     v_in,
  input  div_tok_t tok_in,
  output logic     v_out,
  output div_tok_t tok_out
);

  logic     ge;
  div_tok_t tok_nxt;
  logic     v_r;
  div_tok_t tok_r;

  // one restoring quotient bit, divisor slides right each cell
  always_comb begin
    ge = {{(DSW-NW){1'b0}}, tok_in.rem} >= tok_in.dsh;
    tok_nxt     = tok_in;
    tok_nxt.rem = ge ? tok_in.rem - tok_in.dsh[NW-1:0] : tok_in.rem;
    tok_nxt.q   = {tok_in.q[QB-2:0], ge};
    tok_nxt.dsh = tok_in.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    tok_r <= tok_nxt;
  end

  assign v_out   = v_r;
  assign tok_out = tok_r;

endmodule

// ===== design/adc_sensor_linearizer.sv =====
`timescale 1ns / 1ps
// sensor linearizer: one converter code plus a sensor kind in, one signed value in units of
// 2^-FRAC_BITS and a status out. a request is taken in every clock cycle (busy stays low) and
// its result shows on out_res for a single cycle with out_valid high; every request walks
// through the 28-cell log2 chain and the 25-cell divider chain, whatever its kind. there is
// no back-pressure: the receiver must take each result in the cycle it appears. configuration
// writes take effect at once and must only be made while no request is in flight.

module adc_sensor_linearizer import alin_pkg::*; #(
  parameter int CODE_BITS = DEF_CODE_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  alin_in_t              in_req,
  output logic                  out_valid,
  output alin_out_t             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // full-scale code and the fixed divisors of the linear kinds
  localparam longint FS_I     = (64'sd1 <<< CODE_BITS) - 64'sd1;
  localparam longint D_HUM_I  = FS_I * 30;
  localparam longint D_DIE_I  = FS_I * 5;
  localparam longint D_REF_I  = FS_I * 1000;
  localparam longint DIE_OFS  = FS_I * 1395;
  localparam longint OFF_I    = ((64'sd27315 <<< FRAC_BITS) + 64'sd50) / 100;
  localparam int     TH_SHIFT = 16 + FRAC_BITS;

  localparam logic [11:0]   RAW_MASK = 12'(FS_I);
  localparam logic [FS_W-1:0] FS     = FS_W'(FS_I);
  localparam logic [DW-1:0] D_HUM    = DW'(D_HUM_I);
  localparam logic [DW-1:0] D_DIE    = DW'(D_DIE_I);
  localparam logic [DW-1:0] D_REF    = DW'(D_REF_I);
  localparam logic [LNW-1:0] H_HUM   = LNW'(D_HUM_I / 2);
  localparam logic [LNW-1:0] H_DIE   = LNW'(D_DIE_I / 2);
  localparam logic [LNW-1:0] H_REF   = LNW'(D_REF_I / 2);
  localparam logic signed [28:0] DIE_K = 29'(DIE_OFS);
  localparam logic signed [26:0] OFF   = 27'(OFF_I);
  localparam logic [29:0] LN2_Q30      = 30'd744261118;

  // ---------------------------------------------------------------- config registers
  logic [11:0] vref_r;
  logic [13:0] beta_r;
  logic [19:0] r0_r, r1_r, r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= 12'd3300;
      beta_r <= 14'd3435;
      r0_r   <= 20'd10000;
      r1_r   <= 20'd10000;
      r2_r   <= 20'd14970;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VREF:  vref_r <= cfg_wdata[11:0];
        CFG_BETA:  beta_r <= cfg_wdata[13:0];
        CFG_NOM:   r0_r   <= cfg_wdata;
        CFG_UPPER: r1_r   <= cfg_wdata;
        CFG_LOWER: r2_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // every request is taken; nothing upstream ever waits
  assign busy = 1'b0;

  // ---------------------------------------------------------------- p1: capture request
  logic        p1_v_r;
  logic [2:0]  p1_op_r;
  logic [11:0] p1_raw_r;
  logic [20:0] s_r;  // divider sum r1 + r2

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= start;
    end
    p1_op_r  <= in_req.op;
    p1_raw_r <= in_req.raw_code & RAW_MASK;
    s_r      <= 21'(r1_r) + 21'(r2_r);
  end

  // ---------------------------------------------------------------- p2: first products
  logic          p2_v_r;
  logic [2:0]    p2_op_r;
  logic [AW-1:0] a_r;   // raw * s
  logic [BW-1:0] b_r;   // fs * r2
  logic [23:0]   rv_r;  // raw * vref

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
    p2_op_r <= p1_op_r;
    a_r     <= AW'(p1_raw_r) * AW'(s_r);
    b_r     <= BW'(FS) * BW'(r2_r);
    rv_r    <= 24'(p1_raw_r) * 24'(vref_r);
  end

  // ---------------------------------------------------------------- p3: log operands
  logic signed [28:0] die_x;
  logic [28:0]        die_mag;
  side_t              p3_side_nxt;

  always_comb begin
    die_x   = $signed({4'b0, rv_r, 1'b0}) - DIE_K;
    die_mag = die_x[28] ? 29'(-die_x) : 29'(die_x);
    p3_side_nxt.op  = p2_op_r;
    p3_side_nxt.neg = (p2_op_r == OP_DIE) && die_x[28];
    // thermistor: infinite resistance first, then zero or negative
    if (a_r == '0 || r0_r == '0) begin
      p3_side_nxt.tflag = TF_MIN;
    end else if (BW'(a_r) >= b_r) begin
      p3_side_nxt.tflag = TF_MAX;
    end else begin
      p3_side_nxt.tflag = TF_NONE;
    end
    // linear kinds: numerator magnitude with half the divisor added for rounding
    unique case (p2_op_r)
      OP_HUM:  p3_side_nxt.lin_n = (LNW'(rv_r) << FRAC_BITS) + H_HUM;
      OP_DIE:  p3_side_nxt.lin_n = (LNW'(die_mag) << FRAC_BITS) + H_DIE;
      OP_REF:  p3_side_nxt.lin_n = (LNW'(rv_r) << FRAC_BITS) + H_REF;
      OP_BAT:  p3_side_nxt.lin_n = (LNW'(rv_r) << (FRAC_BITS + 1)) + H_REF;
      default: p3_side_nxt.lin_n = '0;
    endcase
  end

  logic          p3_v_r;
  logic [LW-1:0] n_r, d_r;  // resistance ratio numerator and denominator
  side_t         p3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= p2_v_r;
    end
    n_r       <= LW'(s_r) * LW'(b_r - BW'(a_r));
    d_r       <= LW'(a_r) * LW'(r0_r);
    p3_side_r <= p3_side_nxt;
  end

  // ---------------------------------------------------------------- p4: leading one
  logic [PW-1:0] pn_nxt, pd_nxt;

  always_comb begin
    pn_nxt = '0;
    pd_nxt = '0;
    for (int i = 0; i < LW; i++) begin
      if (n_r[i]) pn_nxt = PW'(i);
      if (d_r[i]) pd_nxt = PW'(i);
    end
  end

  logic          p4_v_r;
  logic [LW-1:0] p4_n_r, p4_d_r;
  logic [PW-1:0] p4_pn_r, p4_pd_r;
  side_t         p4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else begin
      p4_v_r <= p3_v_r;
    end
    p4_n_r    <= n_r;
    p4_d_r    <= d_r;
    p4_pn_r   <= pn_nxt;
    p4_pd_r   <= pd_nxt;
    p4_side_r <= p3_side_r;
  end

  // ---------------------------------------------------------------- p5: normalize, then log chain
  logic [LW+MW-2:0] wn, wd;
  log_tok_t         tok_in_nxt;

  always_comb begin
    // mantissa in [2^31, 2^32): operand * 2^31 >> p
    wn = {p4_n_r, {(MW-1){1'b0}}} >> p4_pn_r;
    wd = {p4_d_r, {(MW-1){1'b0}}} >> p4_pd_r;
    tok_in_nxt.mn   = wn[MW-1:0];
    tok_in_nxt.md   = wd[MW-1:0];
    tok_in_nxt.fn   = '0;
    tok_in_nxt.fd   = '0;
    tok_in_nxt.pn   = p4_pn_r;
    tok_in_nxt.pd   = p4_pd_r;
    tok_in_nxt.side = p4_side_r;
  end

  logic     lg_v0_r;
  log_tok_t lg_tok0_r;
  logic     lg_v [FW+1];
  log_tok_t lg_tok [FW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_v0_r <= 1'b0;
    end else begin
      lg_v0_r <= p4_v_r;
    end
    lg_tok0_r <= tok_in_nxt;
  end

  assign lg_v[0]   = lg_v0_r;
  assign lg_tok[0] = lg_tok0_r;

  // 28 squaring cells, one fraction bit each
  for (genvar g = 0; g < FW; g++) begin : g_log
    alin_log_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (lg_v[g]),
      .tok_in  (lg_tok[g]),
      .v_out   (lg_v[g+1]),
      .tok_out (lg_tok[g+1])
    );
  end

  // ---------------------------------------------------------------- l1: log difference
  logic signed [PW+FW:0] diff_nxt;
  logic                  l1_v_r, l1_neg_r;
  logic [PW+FW-1:0]      l1_mag_r;
  side_t                 l1_side_r;

  assign diff_nxt = $signed({1'b0, lg_tok[FW].pn, lg_tok[FW].fn})
                  - $signed({1'b0, lg_tok[FW].pd, lg_tok[FW].fd});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= 1'b0;
    end else begin
      l1_v_r <= lg_v[FW];
    end
    l1_neg_r  <= diff_nxt[PW+FW];
    l1_mag_r  <= diff_nxt[PW+FW] ? (PW+FW)'(-diff_nxt) : (PW+FW)'(diff_nxt);
    l1_side_r <= lg_tok[FW].side;
  end

  // ---------------------------------------------------------------- l2: natural log, q16
  logic [63:0]        ln_prod;
  logic [21:0]        lnmag;
  logic               l2_v_r;
  logic signed [23:0] lnq_r;
  side_t              l2_side_r;

  always_comb begin
    ln_prod = 64'(l1_mag_r) * 64'(LN2_Q30) + (64'd1 << 41);
    lnmag   = ln_prod[63:42];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_v_r <= 1'b0;
    end else begin
      l2_v_r <= l1_v_r;
    end
    lnq_r     <= l1_neg_r ? -$signed({2'b0, lnmag}) : $signed({2'b0, lnmag});
    l2_side_r <= l1_side_r;
  end

  // ---------------------------------------------------------------- l3: beta denominator
  logic               l3_v_r;
  logic signed [39:0] den_r;
  logic [28:0]        btn_r;  // beta * 29815
  side_t              l3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l3_v_r <= 1'b0;
    end else begin
      l3_v_r <= l2_v_r;
    end
    den_r     <= 40'(lnq_r) * 40'sd29815 + $signed({26'b0, beta_r}) * 40'sd6553600;
    btn_r     <= 29'(beta_r) * 29'd29815;
    l3_side_r <= l2_side_r;
  end

  // ---------------------------------------------------------------- l4: divider operands
  logic [NW-1:0] num_nxt;
  logic [DW-1:0] dvs_nxt;
  div_side_t     l4_side_nxt;

  always_comb begin
    l4_side_nxt.op    = l3_side_r.op;
    l4_side_nxt.neg   = l3_side_r.neg;
    l4_side_nxt.ovf   = 1'b0;
    l4_side_nxt.tflag = l3_side_r.tflag;
    if (l3_side_r.tflag == TF_NONE && den_r <= 40'sd0) begin
      l4_side_nxt.tflag = TF_MAX;
    end
    num_nxt = NW'(l3_side_r.lin_n);
    unique case (l3_side_r.op)
      OP_HUM:   dvs_nxt = D_HUM;
      OP_DIE:   dvs_nxt = D_DIE;
      OP_THERM: begin
        dvs_nxt = den_r[DW-1:0];
        num_nxt = (NW'(btn_r) << TH_SHIFT) + NW'(den_r[DW-1:1]);
      end
      default:  dvs_nxt = D_REF;
    endcase
  end

  logic          l4_v_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] dvs_r;
  div_side_t     l4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l4_v_r <= 1'b0;
    end else begin
      l4_v_r <= l3_v_r;
    end
    num_r     <= num_nxt;
    dvs_r     <= dvs_nxt;
    l4_side_r <= l4_side_nxt;
  end

  // ---------------------------------------------------------------- l5: overflow check, divider
  div_tok_t dv_in_nxt;

  always_comb begin
    dv_in_nxt.side     = l4_side_r;
    // quotient beyond QB bits saturates anyway
    dv_in_nxt.side.ovf = DSW'(num_r) >= (DSW'(dvs_r) << QB);
    dv_in_nxt.rem      = num_r;
    dv_in_nxt.dsh      = DSW'(dvs_r) << (QB - 1);
    dv_in_nxt.q        = '0;
  end

  logic     dv_v0_r;
  div_tok_t dv_tok0_r;
  logic     dv_v [QB+1];
  div_tok_t dv_tok [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v0_r <= 1'b0;
    end else begin
      dv_v0_r <= l4_v_r;
    end
    dv_tok0_r <= dv_in_nxt;
  end

  assign dv_v[0]   = dv_v0_r;
  assign dv_tok[0] = dv_tok0_r;

  for (genvar g = 0; g < QB; g++) begin : g_div
    alin_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (dv_v[g]),
      .tok_in  (dv_tok[g]),
      .v_out   (dv_v[g+1]),
      .tok_out (dv_tok[g+1])
    );
  end

  // ---------------------------------------------------------------- final: sign, offset, clamp
  logic [QB-1:0]      qf;
  div_side_t          sf;
  logic signed [26:0] th_t;
  alin_out_t          res_nxt;

  always_comb begin
    qf   = dv_tok[QB].q;
    sf   = dv_tok[QB].side;
    th_t = $signed({2'b0, qf}) - OFF;
    res_nxt.value  = '0;
    res_nxt.status = ST_OK;
    priority if (sf.op == OP_THERM) begin
      if (sf.tflag == TF_MIN) begin
        res_nxt.value  = VAL_MIN;
        res_nxt.status = ST_RANGE;
      end else if (sf.tflag == TF_MAX) begin
        res_nxt.value  = VAL_MAX;
        res_nxt.status = ST_RANGE;
      end else if (sf.ovf || th_t > 27'sd8388607) begin
        res_nxt.value = VAL_MAX;
      end else if (th_t < -27'sd8388608) begin
        res_nxt.value = VAL_MIN;
      end else begin
        res_nxt.value = th_t[23:0];
      end
    end else if (sf.op > OP_BAT) begin
      // unknown kind
      res_nxt.status = ST_UNKNOWN;
    end else if (sf.neg) begin
      res_nxt.value = (sf.ovf || qf > QB'(25'd8388608)) ? VAL_MIN
                                                        : 24'(-$signed({1'b0, qf}));
    end else begin
      res_nxt.value = (sf.ovf || qf > QB'(25'd8388607)) ? VAL_MAX : qf[23:0];
    end
  end

  logic      out_valid_r;
  alin_out_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v[QB];
    end
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ---------------------------------------------------------------- checks
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_UNKNOWN |-> out_res.value == 24'sd0)
    else $error("unknown kind with nonzero value");

  a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_RANGE |->
      out_res.value == VAL_MAX || out_res.value == VAL_MIN)
    else $error("out-of-range status without saturated value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.status != 2'd3)
    else $error("illegal status code");

endmodule

// ===== bench/adc_sensor_linearizer_tb.sv =====
`timescale 1ns / 1ps

module adc_sensor_linearizer_tb;
  import alin_pkg::*;

  // result latency of the block, plus margin for the drain at the end
  localparam int DRAIN_CYCLES = 80;
  // cycles with neither a request taken nor a result seen before giving up
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEMS_PER_SETTING = 86;
  localparam int NUM_SETTINGS = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  alin_in_t              in_req;
  logic                  out_valid;
  alin_out_t             out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adc_sensor_linearizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow copy of the calibration registers
  longint unsigned vref_reg;
  longint unsigned beta_reg;
  longint unsigned r0_reg;
  longint unsigned r1_reg;
  longint unsigned r2_reg;

  alin_out_t readings_due[$];
  int        err_count;
  int        quiet_cycles;

  // one row of the directed table; the expectation is typed in only where it is obvious
  typedef struct {
    logic [2:0]  op;
    logic [11:0] raw;
    bit          known;
    int          value;
    logic [1:0]  status;
  } dir_row_t;

  dir_row_t dir_table [0:18] = '{
    '{3'd5,     12'd0,     1'b1, 0,        ST_UNKNOWN},
    '{3'd6,     12'd4095,  1'b1, 0,        ST_UNKNOWN},
    '{3'd7,     12'hAAA,   1'b1, 0,        ST_UNKNOWN},
    '{OP_THERM, 12'd0,     1'b1, -8388608, ST_RANGE},   // open thermistor: infinite ohms
    '{OP_THERM, 12'd4095,  1'b1, 8388607,  ST_RANGE},   // code past the divider top
    '{OP_HUM,   12'd0,     1'b1, 0,        ST_OK},
    '{OP_HUM,   12'd4095,  1'b1, 28160,    ST_OK},
    '{OP_DIE,   12'd0,     1'b1, -71424,   ST_OK},
    '{OP_REF,   12'd0,     1'b1, 0,        ST_OK},
    '{OP_REF,   12'd4095,  1'b1, 845,      ST_OK},
    '{OP_BAT,   12'd4095,  1'b1, 1690,     ST_OK},
    '{OP_THERM, 12'd2048,  1'b0, 0,        ST_OK},
    '{OP_THERM, 12'd1000,  1'b0, 0,        ST_OK},
    '{OP_THERM, 12'd1,     1'b0, 0,        ST_OK},
    '{OP_DIE,   12'd4095,  1'b0, 0,        ST_OK},
    '{OP_DIE,   12'd2110,  1'b0, 0,        ST_OK},
    '{OP_HUM,   12'h555,   1'b0, 0,        ST_OK},
    '{OP_REF,   12'hAAA,   1'b0, 0,        ST_OK},
    '{OP_BAT,   12'd1,     1'b0, 0,        ST_OK}
  };

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // divide rounding to nearest, ties away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // log2 with 28 fraction bits by repeated squaring of a 32-bit mantissa
  function automatic longint unsigned log2_frac28(longint unsigned x);
    int              msb;
    longint unsigned mant;
    longint unsigned acc;
    msb = 63;
    while (msb > 0 && x[msb] == 1'b0) msb--;
    mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    acc = longint'(msb) << 28;
    for (int i = 27; i >= 0; i--) begin
      mant = (mant * mant) >> 31;
      if (mant >= (64'd1 << 32)) begin
        mant = mant >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  // beta equation on the divider reading, result in kelvin then shifted to celsius
  function automatic alin_out_t ntc_celsius(longint unsigned raw);
    alin_out_t       res;
    longint unsigned sum_r, a, b, num_r, den_r, mag, ln_mag, num, tk;
    longint          diff, ln_q, den;
    sum_r = r1_reg + r2_reg;
    a = raw * sum_r;
    b = 64'd4095 * r2_reg;
    res.status = ST_RANGE;
    if (a == 0 || r0_reg == 0) begin
      res.value = VAL_MIN;
      return res;
    end
    if (a >= b) begin
      res.value = VAL_MAX;
      return res;
    end
    num_r = sum_r * (b - a);
    den_r = a * r0_reg;
    diff = longint'(log2_frac28(num_r)) - longint'(log2_frac28(den_r));
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    ln_mag = (mag * 64'd744261118 + (64'd1 << 41)) >> 42;
    ln_q = (diff < 0) ? -longint'(ln_mag) : longint'(ln_mag);
    den = ln_q * 29815 + longint'(beta_reg) * 100 * 65536;
    if (den <= 0) begin
      res.value = VAL_MAX;
      return res;
    end
    num = (beta_reg * 64'd29815) << 24;
    tk = (num + longint'(den) / 2) / longint'(den);
    res.value = 24'(sat24(longint'(tk) - 69926));
    res.status = ST_OK;
    return res;
  endfunction

  function automatic alin_out_t linearize(logic [2:0] op, logic [11:0] raw);
    alin_out_t res;
    longint    rv;
    rv = longint'(raw) * longint'(vref_reg);
    res.status = ST_OK;
    case (op)
      OP_HUM:   res.value = 24'(sat24(round_div(rv * 256, 4095 * 30)));
      OP_THERM: res = ntc_celsius(64'(raw));
      OP_DIE:   res.value = 24'(sat24(round_div((2 * rv - 1395 * 4095) * 256, 5 * 4095)));
      OP_REF:   res.value = 24'(sat24(round_div(rv * 256, 4095 * 1000)));
      OP_BAT:   res.value = 24'(sat24(round_div(2 * rv * 256, 4095 * 1000)));
      default: begin
        res.value = '0;
        res.status = ST_UNKNOWN;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    alin_out_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected result, value", out_res.value, 0);
        end else begin
          want = readings_due.pop_front();
          if (out_res.value !== want.value)
            report_mismatch("value", out_res.value, want.value);
          if (out_res.status !== want.status)
            report_mismatch("status", out_res.status, want.status);
        end
      end
    end
  end

  // writes all five registers back to back; called at a clock edge
  task automatic load_calibration(longint unsigned vref, longint unsigned beta,
                                  longint unsigned r0, longint unsigned r1,
                                  longint unsigned r2);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idxs [5];
    vals = '{20'(vref), 20'(beta), 20'(r0), 20'(r1), 20'(r2)};
    idxs = '{CFG_VREF, CFG_BETA, CFG_NOM, CFG_UPPER, CFG_LOWER};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    vref_reg = vref & 64'hFFF;
    beta_reg = beta & 64'h3FFF;
    r0_reg = r0 & 64'hFFFFF;
    r1_reg = r1 & 64'hFFFFF;
    r2_reg = r2 & 64'hFFFFF;
  endtask

  // issues one request; entered and left in the step of a clock edge
  task automatic issue_request(logic [2:0] op, logic [11:0] raw, int idle_pct);
    alin_in_t req;
    req.op = op;
    req.raw_code = raw;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    readings_due.push_back(linearize(op, raw));
  endtask

  // sender pauses at an edge until every result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    alin_out_t   row_want;
    int          idle_pct;
    logic [2:0]  op;
    logic [11:0] raw;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_count = 0;
    quiet_cycles = 0;
    vref_reg = 3300;
    beta_reg = 3435;
    r0_reg = 10000;
    r1_reg = 10000;
    r2_reg = 14970;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset calibration
    foreach (dir_table[i]) begin
      issue_request(dir_table[i].op, dir_table[i].raw, 0);
      if (dir_table[i].known) begin
        row_want.value = 24'(dir_table[i].value);
        row_want.status = dir_table[i].status;
        readings_due[readings_due.size() - 1] = row_want;
      end
    end
    drain_results();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      // block is idle here: move to the next calibration
      case (s)
        1: load_calibration(1000, 1000, 100, 1, 1);
        2: load_calibration(3600, 10000, 1000000, 1000000, 1000000);
        3: load_calibration(4095, 16383, 1048575, 1048575, 1048575);
        4: load_calibration(0, 0, 10000, 10000, 14970);      // zero beta, zero vref
        5: load_calibration(2048, 3950, 0, 0, 0);            // no divider, no r0
        6: load_calibration(3300, 3435, 10000, 5000, 0);     // shorted lower leg
        7: load_calibration($urandom_range(3600, 1000), $urandom_range(10000, 1000),
                            $urandom_range(1000000, 100), $urandom_range(1000000, 1),
                            $urandom_range(1000000, 1));
        default: ;
      endcase
      case (s % 4)
        1: idle_pct = 57;
        3: idle_pct = 18;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        op = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        case ($urandom_range(9))
          0: raw = 12'd0;
          1: raw = 12'd4095;
          2: raw = 12'($urandom_range(15));
          default: raw = 12'($urandom_range(4095));
        endcase
        issue_request(op, raw, idle_pct);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
